@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked on every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked on every rising clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fmbq_pkg.sv @@
`default_nettype none

package fmbq_pkg;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_MID   = 3'd1;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_POP_MID    = 3'd4;
  localparam logic [2:0] ACT_POP_BACK   = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_PUSH_RD   = 7'b0000010,
    S_PUSH_WR   = 7'b0000100,
    S_POP_FETCH = 7'b0001000,
    S_POP_TAKE  = 7'b0010000,
    S_POP_RD    = 7'b0100000,
    S_POP_WR    = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/front_middle_back_queue_core.sv @@
`default_nettype none

// Ordered store of up to DEPTH signed words with push and pop at the front, the middle
// (frontmost of two middles) or the back. A command is taken when start is high and busy
// is low; its result appears for exactly one cycle with done high and must be captured
// then, since the block cannot be stalled. The words sit in one single-port memory, and
// a step counter moves them one position at a time through it, by a read state and then
// a write state per word moved. A push ends in S_PUSH_RD and a pop in S_POP_RD, and done
// follows in the next cycle; a push on a full queue, a pop on an empty
// one and an unused action code answer in the cycle after start. The next command may be
// started in the cycle in which done is shown.

module front_middle_back_queue_core #(
  parameter int DEPTH = 64
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [2:0]                       action,
  input  wire  signed [31:0]               value,
  output logic                             done,
  output logic signed [31:0]               popped_value,
  output logic                             was_empty,
  output logic                             push_dropped,
  output logic [$clog2(DEPTH + 1) - 1:0]   new_count
);

  import fmbq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          done_next;

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic          rd_en;
  logic          we;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  logic [AW-1:0] idx;
  logic [AW-1:0] pos;
  logic [31:0]   val;
  logic [AW-1:0] idx_step;
  logic [AW-1:0] pos_sel;
  logic [AW-1:0] last;
  logic [CW-1:0] count_m1;
  logic          is_push;
  logic          is_pop;
  logic          is_full;
  logic          is_empty;

  assign busy      = (state != S_IDLE);
  assign new_count = count;
  assign count_m1  = count - CW'(1);
  assign last      = count_m1[AW-1:0];
  assign is_full   = (count == FULL_COUNT);
  assign is_empty  = (count == '0);
  assign is_push   = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_MID) ||
                     (action == ACT_PUSH_BACK);
  assign is_pop    = (action == ACT_POP_FRONT) || (action == ACT_POP_MID) ||
                     (action == ACT_POP_BACK);

  // The one incrementer/decrementer shared by every shifting step.
  assign idx_step = (state == S_POP_RD || state == S_POP_WR) ? idx + AW'(1) : idx - AW'(1);

  always_comb begin
    case (action)
      ACT_PUSH_FRONT: pos_sel = '0;
      ACT_PUSH_MID:   pos_sel = AW'(count >> 1);
      ACT_PUSH_BACK:  pos_sel = AW'(count);
      ACT_POP_FRONT:  pos_sel = '0;
      ACT_POP_MID:    pos_sel = AW'(count_m1 >> 1);
      ACT_POP_BACK:   pos_sel = AW'(count_m1);
      default:        pos_sel = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    done_next  = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    raddr      = idx_step;
    waddr      = idx;
    wdata      = rdata;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (is_push && !is_full) begin
            state_next = S_PUSH_RD;
          end else if (is_pop && !is_empty) begin
            state_next = S_POP_FETCH;
          end else begin
            done_next = 1'b1;
          end
        end
      end
      S_PUSH_RD: begin
        if (idx == pos) begin
          we         = 1'b1;
          waddr      = pos;
          wdata      = val;
          count_next = count + CW'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_PUSH_WR;
        end
      end
      S_PUSH_WR: begin
        we         = 1'b1;
        state_next = S_PUSH_RD;
      end
      S_POP_FETCH: begin
        rd_en      = 1'b1;
        raddr      = idx;
        state_next = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        state_next = S_POP_RD;
      end
      S_POP_RD: begin
        if (idx == last) begin
          count_next = count_m1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_POP_WR;
        end
      end
      S_POP_WR: begin
        we         = 1'b1;
        state_next = S_POP_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          val          <= value;
          pos          <= pos_sel;
          idx          <= is_push ? AW'(count) : pos_sel;
          popped_value <= (is_pop && is_empty) ? '1 : '0;
          was_empty    <= is_pop && is_empty;
          push_dropped <= is_push && is_full;
        end
      end
      S_POP_TAKE: begin
        popped_value <= rdata;
      end
      S_PUSH_WR, S_POP_WR: begin
        idx <= idx_step;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/fmbq_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module fmbq_checker #(
  parameter int DEPTH = 64
) (
  input wire                            clk,
  input wire                            rst,
  input wire                            start,
  input wire                            busy,
  input wire [2:0]                      action,
  input wire                            done,
  input wire signed [31:0]              popped_value,
  input wire                            was_empty,
  input wire                            push_dropped,
  input wire [$clog2(DEPTH + 1) - 1:0]  new_count
);

  import fmbq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic take_push;
  logic take_pop;
  logic full_push;
  logic empty_pop;
  logic drop_seen;
  logic empty_seen;
  logic count_ok;

  assign take_push  = start && !busy && ((action == ACT_PUSH_FRONT) ||
                      (action == ACT_PUSH_MID) || (action == ACT_PUSH_BACK));
  assign take_pop   = start && !busy && ((action == ACT_POP_FRONT) ||
                      (action == ACT_POP_MID) || (action == ACT_POP_BACK));
  assign full_push  = take_push && (new_count == CW'(DEPTH));
  assign empty_pop  = take_pop && (new_count == '0);
  assign drop_seen  = done && push_dropped && !was_empty;
  assign empty_seen = done && was_empty && (popped_value == -32'sd1);
  assign count_ok   = rst || (new_count <= CW'(DEPTH));

  `CHK_ASSERT(a_done_when_idle, clk, rst, done |-> !busy, "done shown while busy")
  `CHK_ASSERT(a_full_push_dropped, clk, rst, full_push |=> drop_seen, "full push not dropped")
  `CHK_ASSERT(a_empty_pop, clk, rst, empty_pop |=> empty_seen, "empty pop misreported")
  `CHK_ASSERT(a_empty_count, clk, rst, done && was_empty |-> new_count == '0, "empty flag, count")
  `CHK_ASSERT_ALWAYS(a_count_bound, clk, count_ok, "count above depth")

endmodule

bind front_middle_back_queue_core fmbq_checker #(.DEPTH(DEPTH)) u_fmbq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .action       (action),
  .done         (done),
  .popped_value (popped_value),
  .was_empty    (was_empty),
  .push_dropped (push_dropped),
  .new_count    (new_count)
);

`default_nettype wire

@@ bench/front_middle_back_queue_core_tb.sv @@
`timescale 1ns / 1ps

module front_middle_back_queue_core_tb;
  import fmbq_pkg::*;

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_TARGET = 520;
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  typedef struct {
    logic [2:0]         act;
    logic signed [31:0] val;
    int unsigned        idle_pct;
  } queue_cmd_t;

  typedef struct {
    logic signed [31:0] popped;
    logic               empty;
    logic               dropped;
    logic [6:0]         count;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [2:0]         action = ACT_PUSH_FRONT;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] popped_value;
  logic               was_empty;
  logic               push_dropped;
  logic [6:0]         new_count;

  queue_cmd_t         cmd_backlog[$];
  queue_result_t      pending_results[$];
  logic signed [31:0] model_words[$];
  queue_cmd_t         next_cmd;
  queue_result_t      got_result;
  queue_result_t      want_result;
  int                 mismatches = 0;
  int                 results_seen = 0;
  int                 stall_cycles = 0;
  int                 cmds_queued = 0;
  int                 gen_count = 0;

  front_middle_back_queue_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .value(value),
    .done(done),
    .popped_value(popped_value),
    .was_empty(was_empty),
    .push_dropped(push_dropped),
    .new_count(new_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic queue_result_t apply_queue_command(logic [2:0] act,
                                                        logic signed [31:0] val);
    queue_result_t r;
    int n;
    int pos;
    r.popped = '0;
    r.empty = 1'b0;
    r.dropped = 1'b0;
    n = model_words.size();
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_MID, ACT_PUSH_BACK: begin
        if (n >= DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          if (act == ACT_PUSH_FRONT) pos = 0;
          else if (act == ACT_PUSH_MID) pos = n / 2;
          else pos = n;
          model_words.insert(pos, val);
        end
      end
      ACT_POP_FRONT, ACT_POP_MID, ACT_POP_BACK: begin
        if (n == 0) begin
          r.popped = -32'sd1;
          r.empty = 1'b1;
        end else begin
          if (act == ACT_POP_FRONT) pos = 0;
          else if (act == ACT_POP_MID) pos = (n - 1) / 2;
          else pos = n - 1;
          r.popped = model_words[pos];
          model_words.delete(pos);
        end
      end
      default: ;
    endcase
    r.count = 7'(model_words.size());
    return r;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic add_cmd(logic [2:0] act, logic signed [31:0] val);
    queue_cmd_t c;
    c.act = act;
    c.val = val;
    if (cmds_queued < RANDOM_TARGET / 3) c.idle_pct = 34;
    else if (cmds_queued < 2 * RANDOM_TARGET / 3) c.idle_pct = 60;
    else c.idle_pct = 0;
    cmd_backlog.insert(cmd_backlog.size(), c);
    cmds_queued++;
    if (act <= ACT_PUSH_BACK && gen_count < DEPTH) gen_count++;
    else if (act >= ACT_POP_FRONT && act <= ACT_POP_BACK && gen_count > 0) gen_count--;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] rand_push();
    return ACT_PUSH_FRONT + 3'($urandom_range(0, 2));
  endfunction

  function automatic logic [2:0] rand_pop();
    return ACT_POP_FRONT + 3'($urandom_range(0, 2));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.insert(pending_results.size(), apply_queue_command(action, value));
      end
      if ((!start || !busy) && cmd_backlog.size() > 0 &&
          $urandom_range(0, 99) >= cmd_backlog[0].idle_pct) begin
        next_cmd = cmd_backlog[0];
        cmd_backlog.delete(0);
        start <= 1'b1;
        action <= next_cmd.act;
        value <= next_cmd.val;
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      got_result.popped = popped_value;
      got_result.empty = was_empty;
      got_result.dropped = push_dropped;
      got_result.count = new_count;
      if (pending_results.size() == 0) begin
        report_error("result arrived with no command outstanding");
      end else begin
        want_result = pending_results[0];
        pending_results.delete(0);
        if (got_result.popped !== want_result.popped)
          report_error($sformatf("popped_value %0d, expected %0d",
                                 got_result.popped, want_result.popped));
        if (got_result.empty !== want_result.empty)
          report_error($sformatf("was_empty %b, expected %b",
                                 got_result.empty, want_result.empty));
        if (got_result.dropped !== want_result.dropped)
          report_error($sformatf("push_dropped %b, expected %b",
                                 got_result.dropped, want_result.dropped));
        if (got_result.count !== want_result.count)
          report_error($sformatf("new_count %0d, expected %0d",
                                 got_result.count, want_result.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int mode;
    logic [2:0] act;

    add_cmd(ACT_POP_FRONT, 32'sh1234_5678);
    add_cmd(ACT_POP_MID, -32'sd1);
    add_cmd(ACT_POP_BACK, 32'sh0000_0000);
    add_cmd(ACT_UNUSED_6, 32'sh7fff_ffff);
    add_cmd(ACT_UNUSED_7, 32'sh8000_0000);
    add_cmd(ACT_PUSH_MID, 32'sh0bad_f00d);
    add_cmd(ACT_PUSH_FRONT, 32'sh7fff_ffff);
    add_cmd(ACT_PUSH_BACK, 32'sh8000_0000);
    add_cmd(ACT_PUSH_MID, 32'sh0000_0000);
    add_cmd(ACT_PUSH_MID, -32'sd1);
    add_cmd(ACT_PUSH_FRONT, 32'sh5555_5555);
    add_cmd(ACT_PUSH_BACK, 32'shaaaa_aaaa);
    add_cmd(ACT_UNUSED_6, -32'sd1);
    add_cmd(ACT_UNUSED_7, 32'sh1111_1111);
    add_cmd(ACT_POP_MID, 32'sh0000_0000);
    add_cmd(ACT_POP_MID, 32'sh0000_0000);
    add_cmd(ACT_POP_FRONT, 32'sh0000_0000);
    add_cmd(ACT_POP_BACK, 32'sh0000_0000);
    add_cmd(ACT_PUSH_MID, 32'sh1234_5678);
    add_cmd(ACT_POP_MID, 32'sh0000_0000);
    add_cmd(ACT_POP_BACK, 32'sh0000_0000);
    add_cmd(ACT_POP_MID, 32'sh0000_0000);
    add_cmd(ACT_POP_MID, 32'sh0000_0000);

    // Long fill and drain runs reach the full and empty corners.
    while (cmds_queued < RANDOM_TARGET) begin
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        while (gen_count < DEPTH) add_cmd(rand_push(), rand_word());
        repeat ($urandom_range(1, 3)) add_cmd(rand_push(), rand_word());
      end else if (mode == 1) begin
        while (gen_count > 0) add_cmd(rand_pop(), rand_word());
        repeat ($urandom_range(1, 3)) add_cmd(rand_pop(), rand_word());
      end else begin
        repeat ($urandom_range(10, 40)) begin
          if ($urandom_range(0, 99) < 4) act = 3'($urandom_range(ACT_UNUSED_6, ACT_UNUSED_7));
          else if ($urandom_range(0, 1) == 1) act = rand_push();
          else act = rand_pop();
          add_cmd(act, rand_word());
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (cmd_backlog.size() != 0 || start || pending_results.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (pending_results.size() != 0)
      report_error($sformatf("%0d words never answered", pending_results.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
